// ----- hw/rtl/wrsi_pkg.sv -----
// ----------------------------------------------------------------------------
// wrsi_pkg: shared definitions for the Wilder RSI stream block
// Widths, fixed-point constants, the controller state type and the command
// and status groups that join the controller and the datapath.
// ----------------------------------------------------------------------------
package wrsi_pkg;

	// Window and fixed-point setup.
	localparam int MAX_WINDOW          = 1024;
	localparam int EXTRA_FRACTION_BITS = 16;
	localparam int PRICE_W             = 32;
	localparam int WIN_W               = 11;
	localparam int WIN_RESET           = 14;
	localparam int N_W                 = $clog2(MAX_WINDOW + 1);
	localparam int REM_W               = $clog2(MAX_WINDOW);
	localparam int ACC_W               = 64;
	localparam int X_W                 = PRICE_W + EXTRA_FRACTION_BITS;

	// Final ratio: both averages are brought below 2^NORM_W first.
	localparam int NORM_W              = 48;
	localparam int RSI_W               = 15;
	localparam int RSI_FULL_SCALE      = 25600;
	localparam int NUM_W               = NORM_W + RSI_W;

	// Iteration counts of the sequential units.
	localparam int MUL_STEPS           = REM_W;
	localparam int DIV_STEPS           = ACC_W;
	localparam int FDIV_STEPS          = RSI_W;
	localparam int STEP_W              = $clog2(ACC_W);

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_ADDX,
		ST_DIV,
		ST_NORM,
		ST_FSET,
		ST_FDIV,
		ST_DONE
	} wrsi_state_t;

	// What the arriving price asks for.
	typedef enum logic [1:0] {
		FR_NONE,
		FR_SEED,
		FR_SMOOTH
	} wrsi_front_t;

	typedef struct packed {
		logic front;
		logic mul_step;
		logic add_x;
		logic div_step;
		logic div_last;
		logic norm_step;
		logic fset;
		logic fdiv_step;
		logic load_out;
	} wrsi_cmd_t;

	typedef struct packed {
		wrsi_front_t front_kind;
		logic        norm_busy;
	} wrsi_sts_t;

endpackage

// ----- hw/rtl/wrsi_ctrl.sv -----
// ----------------------------------------------------------------------------
// wrsi_ctrl: sequencer of the Wilder RSI stream block
// Steps the datapath through multiply, divide, normalize and ratio phases
// and owns the input and output handshakes.
// ----------------------------------------------------------------------------
module wrsi_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               out_ready,
	output logic               out_valid,
	input  wrsi_pkg::wrsi_sts_t sts,
	output wrsi_pkg::wrsi_cmd_t cmd
);
	import wrsi_pkg::*;

	wrsi_state_t        state_q, state_d;
	logic [STEP_W-1:0]  step_q;
	logic [STEP_W-1:0]  step_load_c;
	logic               out_valid_q;
	logic               step_zero_c;
	logic               out_free_c;

	assign step_zero_c = (step_q == '0);
	assign out_free_c  = !out_valid_q || out_ready;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (sts.front_kind)
						FR_SEED:   state_d = ST_DIV;
						FR_SMOOTH: state_d = ST_MUL;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_MUL: begin
				if (step_zero_c) state_d = ST_ADDX;
			end
			ST_ADDX: state_d = ST_DIV;
			ST_DIV: begin
				if (step_zero_c) state_d = ST_NORM;
			end
			ST_NORM: begin
				if (!sts.norm_busy) state_d = ST_FSET;
			end
			ST_FSET: state_d = ST_FDIV;
			ST_FDIV: begin
				if (step_zero_c) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free_c) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Commands to the datapath.
	always_comb begin
		cmd           = '0;
		cmd.front     = (state_q == ST_IDLE) && in_valid;
		cmd.mul_step  = (state_q == ST_MUL);
		cmd.add_x     = (state_q == ST_ADDX);
		cmd.div_step  = (state_q == ST_DIV);
		cmd.div_last  = (state_q == ST_DIV) && step_zero_c;
		cmd.norm_step = (state_q == ST_NORM);
		cmd.fset      = (state_q == ST_FSET);
		cmd.fdiv_step = (state_q == ST_FDIV);
		cmd.load_out  = (state_q == ST_DONE) && out_free_c;
	end

	// Iteration count, less one, loaded on entry to a looping state.
	always_comb begin
		case (state_d)
			ST_MUL:  step_load_c = STEP_W'(MUL_STEPS - 1);
			ST_DIV:  step_load_c = STEP_W'(DIV_STEPS - 1);
			ST_FDIV: step_load_c = STEP_W'(FDIV_STEPS - 1);
			default: step_load_c = '0;
		endcase
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	// State, step counter and output beat flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_d != state_q) begin
				step_q <= step_load_c;
			end else if (!step_zero_c) begin
				step_q <= step_q - STEP_W'(1);
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- hw/rtl/wrsi_dp.sv -----
// ----------------------------------------------------------------------------
// wrsi_dp: datapath of the Wilder RSI stream block
// Holds the series state and the averages, and carries two shift-add multipliers,
// two bit-serial dividers by the window and a bit-serial ratio divider.
// ----------------------------------------------------------------------------
module wrsi_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [wrsi_pkg::WIN_W-1:0]   cfg_wdata,
	input  logic [wrsi_pkg::PRICE_W-1:0] price,
	input  logic                         series_start,
	input  wrsi_pkg::wrsi_cmd_t          cmd,
	output wrsi_pkg::wrsi_sts_t          sts,
	output logic [wrsi_pkg::RSI_W-1:0]   rsi_value
);
	import wrsi_pkg::*;

	localparam int LANE_G = 0;
	localparam int LANE_L = 1;

	// Control state.
	logic [WIN_W-1:0]   window_q;
	logic               have_prev_q;
	logic [N_W-1:0]     cnt_q;

	// Payload state.
	logic [PRICE_W-1:0] prev_q;
	logic [ACC_W-1:0]   acc_q  [2];
	logic [ACC_W-1:0]   work_q [2];
	logic [X_W-1:0]     x_q    [2];
	logic [REM_W-1:0]   rem_q  [2];
	logic [REM_W-1:0]   mpl_q;
	logic [N_W-1:0]     n_q;
	logic [NORM_W:0]    den_q;
	logic [NORM_W:0]    frem_q;
	logic [RSI_W-1:0]   fq_q;
	logic               full_q;
	logic [RSI_W-1:0]   rsi_q;

	// Front-end signals.
	logic [N_W-1:0]     n_eff_c;
	logic [N_W-1:0]     cnt_inc_c;
	logic               start_c;
	logic               seeding_c;
	logic [PRICE_W-1:0] up_c;
	logic [PRICE_W-1:0] down_c;
	logic [X_W-1:0]     x_c    [2];
	logic [ACC_W-1:0]   sum_c  [2];

	// Iterative unit signals.
	logic [ACC_W-1:0]   mul_c   [2];
	logic [REM_W:0]     trial_c [2];
	logic [REM_W:0]     diff_c  [2];
	logic               ge_c    [2];
	logic [ACC_W-1:0]   quo_c   [2];
	logic [NUM_W-1:0]   num_c;
	logic [NORM_W+1:0]  ftrial_c;
	logic [NORM_W+1:0]  fdiff_c;
	logic               fge_c;

	// Effective window: zero acts as one, large values clamp.
	always_comb begin
		if (window_q == '0) begin
			n_eff_c = N_W'(1);
		end else if (32'(window_q) > MAX_WINDOW) begin
			n_eff_c = N_W'(MAX_WINDOW);
		end else begin
			n_eff_c = N_W'(window_q);
		end
	end

	// Price change and running sums for the arriving beat.
	always_comb begin
		start_c   = series_start || !have_prev_q;
		up_c      = (price > prev_q) ? (price - prev_q) : '0;
		down_c    = (prev_q > price) ? (prev_q - price) : '0;
		x_c[LANE_G] = {up_c, {EXTRA_FRACTION_BITS{1'b0}}};
		x_c[LANE_L] = {down_c, {EXTRA_FRACTION_BITS{1'b0}}};
		sum_c[LANE_G] = acc_q[LANE_G] + ACC_W'(x_c[LANE_G]);
		sum_c[LANE_L] = acc_q[LANE_L] + ACC_W'(x_c[LANE_L]);
		seeding_c = (cnt_q < n_eff_c);
		cnt_inc_c = cnt_q + N_W'(1);
	end

	// Tell the controller which path the beat takes.
	always_comb begin
		if (start_c) begin
			sts.front_kind = FR_NONE;
		end else if (seeding_c) begin
			sts.front_kind = (cnt_inc_c == n_eff_c) ? FR_SEED : FR_NONE;
		end else begin
			sts.front_kind = FR_SMOOTH;
		end
		sts.norm_busy = (work_q[LANE_G][ACC_W-1:NORM_W] |
			work_q[LANE_L][ACC_W-1:NORM_W]) != '0;
	end

	// Shift-add multiply step and restoring divide step, one per lane.
	always_comb begin
		for (int i = 0; i < 2; i++) begin
			mul_c[i]   = (work_q[i] << 1) + (mpl_q[REM_W-1] ? acc_q[i] : '0);
			trial_c[i] = {rem_q[i], work_q[i][ACC_W-1]};
			ge_c[i]    = (trial_c[i] >= (REM_W + 1)'(n_q));
			diff_c[i]  = trial_c[i] - (REM_W + 1)'(n_q);
			quo_c[i]   = {work_q[i][ACC_W-2:0], ge_c[i]};
		end
	end

	// Ratio setup and divide step.
	always_comb begin
		num_c    = NUM_W'(work_q[LANE_G][NORM_W-1:0]) * NUM_W'(RSI_FULL_SCALE);
		ftrial_c = {frem_q, fq_q[RSI_W-1]};
		fge_c    = (ftrial_c >= (NORM_W + 2)'(den_q));
		fdiff_c  = ftrial_c - (NORM_W + 2)'(den_q);
	end

	// Configuration and series control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q    <= WIN_W'(WIN_RESET);
			have_prev_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (cfg_we) begin
				window_q <= cfg_wdata;
			end
			if (cmd.front) begin
				have_prev_q <= 1'b1;
				if (start_c) begin
					cnt_q <= '0;
				end else if (seeding_c) begin
					cnt_q <= cnt_inc_c;
				end
			end
		end
	end

	// Averages and the working registers of the iterative units.
	always_ff @(posedge clk) begin
		if (cmd.front) begin
			prev_q <= price;
			n_q    <= n_eff_c;
			mpl_q  <= REM_W'(n_eff_c - N_W'(1));
			for (int i = 0; i < 2; i++) begin
				x_q[i]   <= x_c[i];
				rem_q[i] <= '0;
				if (start_c) begin
					acc_q[i] <= '0;
				end else if (seeding_c) begin
					acc_q[i]  <= sum_c[i];
					work_q[i] <= sum_c[i];
				end else begin
					work_q[i] <= '0;
				end
			end
		end
		if (cmd.mul_step) begin
			mpl_q <= mpl_q << 1;
			for (int i = 0; i < 2; i++) begin
				work_q[i] <= mul_c[i];
			end
		end
		if (cmd.add_x) begin
			for (int i = 0; i < 2; i++) begin
				work_q[i] <= work_q[i] + ACC_W'(x_q[i]);
				rem_q[i]  <= '0;
			end
		end
		if (cmd.div_step) begin
			for (int i = 0; i < 2; i++) begin
				work_q[i] <= quo_c[i];
				rem_q[i]  <= REM_W'(ge_c[i] ? diff_c[i] : trial_c[i]);
				if (cmd.div_last) begin
					acc_q[i] <= quo_c[i];
				end
			end
		end
		// Halve both averages together until they fit the ratio divider.
		if (cmd.norm_step && sts.norm_busy) begin
			for (int i = 0; i < 2; i++) begin
				work_q[i] <= work_q[i] >> 1;
			end
		end
		if (cmd.fset) begin
			frem_q <= (NORM_W + 1)'(num_c[NUM_W-1:RSI_W]);
			fq_q   <= num_c[RSI_W-1:0];
			den_q  <= (NORM_W + 1)'(work_q[LANE_G][NORM_W-1:0]) +
				(NORM_W + 1)'(work_q[LANE_L][NORM_W-1:0]);
			full_q <= (acc_q[LANE_L] == '0);
		end
		if (cmd.fdiv_step) begin
			frem_q <= (NORM_W + 1)'(fge_c ? fdiff_c : ftrial_c);
			fq_q   <= {fq_q[RSI_W-2:0], fge_c};
		end
		if (cmd.load_out) begin
			rsi_q <= full_q ? RSI_W'(RSI_FULL_SCALE) : fq_q;
		end
	end

	assign rsi_value = rsi_q;

endmodule

// ----- hw/rtl/wilder_rsi_stream.sv -----
// ----------------------------------------------------------------------------
// wilder_rsi_stream: streaming Wilder relative strength index
// Takes one 16.16 price per input beat and returns RSI in 7.8 fixed point
// once the averages are seeded.
// ----------------------------------------------------------------------------
// Usage:
// Input beats (in_valid/in_ready) carry price and series_start. A beat with
// series_start set, or the first beat after reset, only stores the price.
// The next window_length changes are summed; the last of them seeds the
// averages and yields the first output beat (out_valid/out_ready, rsi_value).
// Every later change updates the averages and yields one output beat.
// A beat that yields no result only updates the series state. A seeding
// beat divides both sums by the window in the one-bit-per-cycle dividers,
// halves both averages until they fit the ratio divider and then forms the
// ratio; a smoothing beat first multiplies both averages by the window less
// one and adds the new change. One beat is worked on at a time.
// The finished result sits in an output register; a new input beat is taken
// while it waits, and only the next finished result stalls on the receiver.
// Reset clears the series and sets window_length to 14. Write window_length
// through cfg_we/cfg_wdata only while the block is idle.
// ----------------------------------------------------------------------------
module wilder_rsi_stream (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [wrsi_pkg::WIN_W-1:0]   cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [wrsi_pkg::PRICE_W-1:0] price,
	input  logic                         series_start,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [wrsi_pkg::RSI_W-1:0]   rsi_value
);
	import wrsi_pkg::*;

	wrsi_cmd_t cmd;
	wrsi_sts_t sts;

	// Sequencer.
	wrsi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Arithmetic and series state.
	wrsi_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.price        (price),
		.series_start (series_start),
		.cmd          (cmd),
		.sts          (sts),
		.rsi_value    (rsi_value)
	);

	// A presented result never exceeds full scale.
	a_rsi_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (rsi_value <= RSI_W'(RSI_FULL_SCALE)))
		else $error("rsi_value above full scale");

	// A series start only stores the price: the block is ready again at once.
	a_start_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && series_start) |=> in_ready)
		else $error("series start did not return to ready");

	// A series start never produces a result beat.
	a_start_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && series_start) |=> !$rose(out_valid))
		else $error("series start produced a result");

	// A new result is only loaded while the sequencer is not taking input.
	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !in_ready)
		else $error("result loaded while accepting input");

endmodule
